@@ rtl/sync_frame_line_demultiplexer_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the framed line demultiplexer
// Each macro expands to one labeled concurrent assertion on clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_LINE_DEMULTIPLEXER_CORE_DEFINES_SVH
`define SYNC_FRAME_LINE_DEMULTIPLEXER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFLD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sfld_pkg.sv @@
// ----------------------------------------------------------------------------
// sfld_pkg
// Shared types and codes of the framed line demultiplexer: commands, line
// states, the classified work item, the result beat and the register port.
// ----------------------------------------------------------------------------
package sfld_pkg;

	// Widest logical line index an address byte can select (address >> 1)
	localparam int LINE_IDX_W = 7;
	// Width of the open mask register
	localparam int MASK_W     = 8;
	// Register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_LINE_OPEN_MASK = 1'b0;

	// Host command codes
	localparam logic [1:0] CMD_RX      = 2'd0;
	localparam logic [1:0] CMD_FETCH   = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	typedef enum logic [1:0] {
		LS_IDLE  = 2'd0,
		LS_FILL  = 2'd1,
		LS_READY = 2'd2
	} line_state_t;

	// Item classes decided by the front part
	typedef enum logic [3:0] {
		K_START,
		K_START_BAD,
		K_END,
		K_END_ERR,
		K_STOP,
		K_DATA,
		K_FETCH,
		K_RELEASE,
		K_NOP
	} item_kind_t;

	typedef struct packed {
		item_kind_t             kind;
		logic [7:0]             rx_byte;
		logic [LINE_IDX_W-1:0]  line;        // start line or host line select
		logic                   line_given;  // else work on the current line
		logic                   line_ok;     // line lies inside the table
		logic [8:0]             byte_offset;
		logic                   abort;
		logic                   overrun;
	} item_t;

	typedef struct packed {
		logic [1:0]  line_state;
		logic [9:0]  line_length;
		logic [7:0]  data_byte;
		logic        message_ready;
		logic [2:0]  ready_line;
		logic        frame_ignored;
		logic [7:0]  line_errors;
		logic [15:0] line_ignored;
		logic [15:0] global_ignored;
		logic [7:0]  abort_count;
		logic [7:0]  overrun_count;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [MASK_W-1:0] mask;
	} cfg_t;

endpackage

@@ rtl/sfld_fifo.sv @@
// ----------------------------------------------------------------------------
// sfld_fifo
// Small register queue with push/full and pop/empty, used between the front
// and back parts and on the result side.
// ----------------------------------------------------------------------------
module sfld_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/sfld_front.sv @@
// ----------------------------------------------------------------------------
// sfld_front
// Accepts input items, classifies them into work items and holds them in a
// short queue until the back part takes them.
// ----------------------------------------------------------------------------
module sfld_front
	import sfld_pkg::*;
#(
	parameter int LINES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic [7:0] rx_byte,
	input  logic       start_of_message,
	input  logic       end_of_message,
	input  logic       receive_error,
	input  logic       overrun,
	input  logic       crc_error,
	input  logic       frame_aborted,
	input  logic [2:0] line_select,
	input  logic [8:0] byte_offset,
	input  logic       q_pop,
	output logic       q_empty,
	output item_t      q_item
);

	item_t item_d;

	// Classify the receiver word or host command
	always_comb begin
		item_d             = '0;
		item_d.rx_byte     = rx_byte;
		item_d.byte_offset = byte_offset;
		item_d.abort       = frame_aborted;
		item_d.overrun     = overrun;
		item_d.line        = LINE_IDX_W'(line_select);
		item_d.line_given  = 1'b1;
		item_d.line_ok     = (8'(line_select) < 8'(LINES));
		item_d.kind        = K_NOP;
		case (cmd)
			CMD_RX: begin
				item_d.line_given = 1'b0;
				item_d.line_ok    = 1'b1;
				if (start_of_message) begin
					item_d.line = rx_byte[7:1];
					if (9'(rx_byte) < 9'(2 * LINES)) begin
						item_d.kind       = K_START;
						item_d.line_given = 1'b1;
					end else begin
						item_d.kind = K_START_BAD;
					end
				end else if (end_of_message) begin
					if (receive_error || frame_aborted || overrun || crc_error) begin
						item_d.kind = K_END_ERR;
					end else begin
						item_d.kind = K_END;
					end
				end else if (frame_aborted || receive_error || overrun) begin
					item_d.kind = K_STOP;
				end else begin
					item_d.kind = K_DATA;
				end
			end
			CMD_FETCH: begin
				item_d.kind = K_FETCH;
			end
			CMD_RELEASE: begin
				item_d.kind = K_RELEASE;
			end
			default: begin
				item_d.kind = K_NOP;
			end
		endcase
	end

	// Hold classified items until the back part is free
	sfld_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (2)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (item_d),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_item)
	);

endmodule

@@ rtl/sfld_back.sv @@
// ----------------------------------------------------------------------------
// sfld_back
// Carries out work items: reads the line record and frame store, updates the
// line state, counters and buffer, and pushes one result beat per item.
// ----------------------------------------------------------------------------
module sfld_back
	import sfld_pkg::*;
#(
	parameter int LINES        = 8,
	parameter int BUFFER_BYTES = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	output logic [MASK_W-1:0] line_open_mask,
	input  logic              item_empty,
	output logic              item_pop,
	input  item_t             item,
	input  logic              res_full,
	output logic              res_push,
	output result_t           res
);

	localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int FW = $clog2(BUFFER_BYTES + 1);
	localparam int AW = $clog2(LINES * BUFFER_BYTES);
	localparam int DEPTH = LINES * BUFFER_BYTES;

	typedef enum logic {
		PH_READ,
		PH_EXEC
	} phase_t;

	typedef enum logic [1:0] {
		MODE_IGNORE = 2'd0,
		MODE_BUSY   = 2'd1,
		MODE_IDLE   = 2'd2
	} rx_mode_t;

	typedef struct packed {
		logic [FW-1:0] fill;
		logic [7:0]    errors;
		logic [15:0]   refused;
	} rec_t;

	// Architectural state
	phase_t            phase_q;
	rx_mode_t          mode_q;
	logic [LW-1:0]     cur_line_q;
	logic [MASK_W-1:0] mask_q;
	line_state_t       state_q [LINES];
	logic [LINES-1:0]  vld_q;
	logic [15:0]       glob_q;
	logic [7:0]        aborts_q;
	logic [7:0]        overruns_q;

	// Memories
	rec_t              line_tbl [LINES];
	logic [7:0]        frame_store [DEPTH];

	// Read stage registers
	item_t             item_s1;
	logic [LW-1:0]     line_s1;
	logic              lok_s1;
	rec_t              tbl_rd_s1;
	logic [7:0]        fs_rd_s1;

	// Read side
	logic [LINE_IDX_W-1:0] rd_line_full;
	logic [LW-1:0]         rd_line;
	logic                  rd_ok;
	logic [AW-1:0]         fetch_addr;

	// Execute side
	rec_t          rec;
	rec_t          rec_n;
	line_state_t   st;
	line_state_t   st_n;
	rx_mode_t      mode_n;
	logic [LW-1:0] cur_n;
	logic [15:0]   glob_n;
	logic [7:0]    aborts_n;
	logic [7:0]    overruns_n;
	logic [7:0]    data;
	logic          ready;
	logic          ignored;
	logic          open;
	logic          fs_we;
	logic [FW-1:0] fs_idx;
	logic [AW-1:0] fs_waddr;
	logic          exec_fire;
	logic [LINES-1:0] closing;

	assign line_open_mask = mask_q;

	// Pick the line of this item and the fetch address
	always_comb begin
		rd_line_full = item.line_given ? item.line : LINE_IDX_W'(cur_line_q);
		rd_ok        = item.line_given ? item.line_ok : 1'b1;
		rd_line      = rd_line_full[LW-1:0];
		fetch_addr   = '0;
		if (rd_ok && (32'(item.byte_offset) < 32'(BUFFER_BYTES))) begin
			fetch_addr = AW'(rd_line) * AW'(BUFFER_BYTES) + AW'(item.byte_offset);
		end
	end

	assign item_pop  = (phase_q == PH_READ) && !item_empty;
	assign exec_fire = (phase_q == PH_EXEC) && !res_full;
	assign res_push  = exec_fire;

	// Register the item and read both memories
	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_s1   <= item;
			line_s1   <= rd_line;
			lok_s1    <= rd_ok;
			tbl_rd_s1 <= line_tbl[rd_line];
			fs_rd_s1  <= frame_store[fetch_addr];
		end
	end

	// Write back the line record and the appended byte
	always_ff @(posedge clk) begin
		if (exec_fire && lok_s1) begin
			line_tbl[line_s1] <= rec_n;
		end
		if (exec_fire && fs_we) begin
			frame_store[fs_waddr] <= item_s1.rx_byte;
		end
	end

	// Work out the item against the line record
	always_comb begin
		rec        = vld_q[line_s1] ? tbl_rd_s1 : '0;
		st         = state_q[line_s1];
		rec_n      = rec;
		st_n       = st;
		mode_n     = mode_q;
		cur_n      = cur_line_q;
		glob_n     = glob_q;
		aborts_n   = aborts_q;
		overruns_n = overruns_q;
		data       = '0;
		ready      = 1'b0;
		ignored    = 1'b0;
		fs_we      = 1'b0;
		fs_idx     = '0;
		open       = (item_s1.line < LINE_IDX_W'(MASK_W)) && mask_q[item_s1.line[2:0]];
		case (item_s1.kind)
			K_START_BAD: begin
				glob_n  = glob_q + 16'd1;
				mode_n  = MODE_IGNORE;
				ignored = 1'b1;
			end
			K_START: begin
				if (!open || (st == LS_READY)) begin
					rec_n.refused = rec.refused + 16'd1;
					mode_n        = MODE_IGNORE;
					ignored       = 1'b1;
				end else begin
					cur_n      = line_s1;
					st_n       = LS_FILL;
					mode_n     = MODE_BUSY;
					rec_n.fill = FW'(1);
					fs_we      = 1'b1;
				end
			end
			K_END_ERR: begin
				rec_n.errors = rec.errors + 8'd1;
				mode_n       = MODE_IDLE;
			end
			K_END: begin
				if ((st == LS_FILL) && (mode_q == MODE_BUSY)) begin
					st_n  = LS_READY;
					ready = 1'b1;
				end
				mode_n = MODE_IDLE;
			end
			K_STOP: begin
				mode_n = MODE_IGNORE;
				if (st == LS_FILL) begin
					st_n = LS_IDLE;
				end
				aborts_n   = aborts_q + 8'(item_s1.abort);
				overruns_n = overruns_q + 8'(item_s1.overrun);
			end
			K_DATA: begin
				if (mode_q == MODE_BUSY) begin
					if (32'(rec.fill) >= 32'(BUFFER_BYTES)) begin
						mode_n = MODE_IGNORE;
					end else begin
						fs_we      = 1'b1;
						fs_idx     = rec.fill;
						rec_n.fill = rec.fill + FW'(1);
					end
				end
			end
			K_FETCH: begin
				if (lok_s1 && (st == LS_READY)
						&& (32'(item_s1.byte_offset) < 32'(rec.fill))
						&& (32'(item_s1.byte_offset) < 32'(BUFFER_BYTES))) begin
					data = fs_rd_s1;
				end
			end
			K_RELEASE: begin
				if (lok_s1 && (st == LS_READY)) begin
					st_n = LS_IDLE;
				end
			end
			default: begin
			end
		endcase
		fs_waddr = AW'(line_s1) * AW'(BUFFER_BYTES) + AW'(fs_idx);
	end

	// Build the result beat for the reported line
	always_comb begin
		res                = '0;
		res.data_byte      = data;
		res.message_ready  = ready;
		res.ready_line     = ready ? 3'(cur_line_q) : 3'd0;
		res.frame_ignored  = ignored;
		res.global_ignored = glob_n;
		res.abort_count    = aborts_n;
		res.overrun_count  = overruns_n;
		if (lok_s1) begin
			res.line_state   = st_n;
			res.line_length  = 10'(rec_n.fill);
			res.line_errors  = rec_n.errors;
			res.line_ignored = rec_n.refused;
		end
	end

	// Lines whose open bit a register write clears
	always_comb begin
		for (int l = 0; l < LINES; l++) begin
			closing[l] = (l < MASK_W) && mask_q[3'(l)] && !cfg.mask[3'(l)];
		end
	end

	// Hold phase, line states, mode and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_READ;
			mode_q     <= MODE_IDLE;
			cur_line_q <= '0;
			mask_q     <= '0;
			vld_q      <= '0;
			glob_q     <= '0;
			aborts_q   <= '0;
			overruns_q <= '0;
			for (int l = 0; l < LINES; l++) begin
				state_q[l] <= LS_IDLE;
			end
		end else begin
			case (phase_q)
				PH_READ: begin
					if (item_pop) begin
						phase_q <= PH_EXEC;
					end
				end
				PH_EXEC: begin
					if (exec_fire) begin
						phase_q    <= PH_READ;
						mode_q     <= mode_n;
						cur_line_q <= cur_n;
						glob_q     <= glob_n;
						aborts_q   <= aborts_n;
						overruns_q <= overruns_n;
						if (lok_s1) begin
							state_q[line_s1] <= st_n;
							vld_q[line_s1]   <= 1'b1;
						end
					end
				end
				default: begin
					phase_q <= PH_READ;
				end
			endcase
			// Register writes must arrive only while no item is in flight; the user is bound, this block does not enforce it
			if (cfg.we) begin
				mask_q <= cfg.mask;
				for (int l = 0; l < LINES; l++) begin
					if (closing[l]) begin
						state_q[l] <= LS_IDLE;
					end
				end
				if (closing[cur_line_q] && (mode_q == MODE_BUSY)) begin
					mode_q <= MODE_IGNORE;
				end
			end
		end
	end

endmodule

@@ rtl/sync_frame_line_demultiplexer_core.sv @@
// ----------------------------------------------------------------------------
// sync_frame_line_demultiplexer_core
// Receive demultiplexer for a framed synchronous line with per-line buffers.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (push/full) carries receiver words (cmd 0) and host commands
// (cmd 1 fetch a buffered byte, cmd 2 release a ready line). A beat is taken
// when push is high and full is low. Every input beat yields one result beat
// on the result channel (empty/pop), oldest first.
// A result passes through the input queue, the read stage registers and the
// result queue before it is visible on the result side.
// The back part takes a new item only after it has executed the last, set by
// the read-then-write of the line record memory and frame store in the back
// part (a read phase, then an execute phase, per item).
// A two-beat queue sits between the front and back parts and another on the
// result side; when pop stays low the back part holds its item in the
// execute cycle and full rises once the input queue fills.
// Reset clears all line states to idle, all counters, the open mask and the
// queues; the frame store is not cleared.
// The APB port writes line_open_mask at address 0; the user must write it only
// while no item is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "sync_frame_line_demultiplexer_core_defines.svh"

module sync_frame_line_demultiplexer_core
	import sfld_pkg::*;
#(
	parameter int LINES        = 8,
	parameter int BUFFER_BYTES = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input queue side
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            cmd,
	input  logic [7:0]            rx_byte,
	input  logic                  start_of_message,
	input  logic                  end_of_message,
	input  logic                  receive_error,
	input  logic                  overrun,
	input  logic                  crc_error,
	input  logic                  frame_aborted,
	input  logic [2:0]            line_select,
	input  logic [8:0]            byte_offset,
	// Result queue side
	output logic                  empty,
	input  logic                  pop,
	output logic [1:0]            line_state,
	output logic [9:0]            line_length,
	output logic [7:0]            data_byte,
	output logic                  message_ready,
	output logic [2:0]            ready_line,
	output logic                  frame_ignored,
	output logic [7:0]            line_errors,
	output logic [15:0]           line_ignored,
	output logic [15:0]           global_ignored,
	output logic [7:0]            abort_count,
	output logic [7:0]            overrun_count,
	// Register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t              cfg;
	logic [MASK_W-1:0] mask;
	logic              item_pop;
	logic              item_empty;
	item_t             item;
	logic              res_push;
	logic              res_full;
	result_t           res_d;
	result_t           res_q;
	logic              ready_ok;

	// Decode register writes and reads
	assign pready   = 1'b1;
	assign cfg.we   = psel && penable && pwrite && pready && (paddr[2] == REG_LINE_OPEN_MASK);
	assign cfg.mask = pwdata[MASK_W-1:0];
	assign prdata   = (paddr[2] == REG_LINE_OPEN_MASK) ? APB_DATA_W'(mask) : '0;

	sfld_front #(
		.LINES (LINES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.cmd              (cmd),
		.rx_byte          (rx_byte),
		.start_of_message (start_of_message),
		.end_of_message   (end_of_message),
		.receive_error    (receive_error),
		.overrun          (overrun),
		.crc_error        (crc_error),
		.frame_aborted    (frame_aborted),
		.line_select      (line_select),
		.byte_offset      (byte_offset),
		.q_pop            (item_pop),
		.q_empty          (item_empty),
		.q_item           (item)
	);

	sfld_back #(
		.LINES        (LINES),
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.line_open_mask (mask),
		.item_empty     (item_empty),
		.item_pop       (item_pop),
		.item           (item),
		.res_full       (res_full),
		.res_push       (res_push),
		.res            (res_d)
	);

	// Queue result beats for the receiver
	sfld_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_d),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_q)
	);

	assign line_state     = res_q.line_state;
	assign line_length    = res_q.line_length;
	assign data_byte      = res_q.data_byte;
	assign message_ready  = res_q.message_ready;
	assign ready_line     = res_q.ready_line;
	assign frame_ignored  = res_q.frame_ignored;
	assign line_errors    = res_q.line_errors;
	assign line_ignored   = res_q.line_ignored;
	assign global_ignored = res_q.global_ignored;
	assign abort_count    = res_q.abort_count;
	assign overrun_count  = res_q.overrun_count;

	// A completed frame reports a ready line, no refusal and no fetched byte
	assign ready_ok = (line_state == LS_READY) && !frame_ignored && (data_byte == 8'd0);

	`SFLD_ASSERT_NOW(a_push_room, res_push, !res_full, "result pushed into a full queue")
	`SFLD_ASSERT_NOW(a_pop_item, item_pop, !item_empty, "item taken from an empty queue")
	`SFLD_ASSERT_NEXT(a_push_shows, res_push, !empty, "pushed result not visible")
	`SFLD_ASSERT_NOW(a_ready_state, !empty && message_ready, ready_ok, "bad ready beat")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for sync_frame_line_demultiplexer_core
// Drives receiver words and host fetch/release commands through the input
// queue, predicts every result beat with a scoreboard that tracks line
// states, buffers and counters, and compares each popped beat field by field.
// Directed words come first, then a full buffer with overflow, then random
// frame traffic under several open masks with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfld_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_WORDS = 310;
	localparam int LINE_COUNT   = 8;
	localparam int BUF_BYTES    = 512;
	localparam int PRINT_LIMIT  = 100;
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam logic [APB_ADDR_W-1:0] OPEN_MASK_ADDR = APB_ADDR_W'(4 * REG_LINE_OPEN_MASK);

	typedef enum logic [1:0] {
		RX_DISCARD,
		RX_BUSY,
		RX_IDLE
	} rx_mode_t;

	// One input beat as the sender builds it
	typedef struct {
		logic [1:0] cmd;
		logic [7:0] rx;
		logic       som;
		logic       eom;
		logic       rerr;
		logic       ovr;
		logic       crc;
		logic       abrt;
		logic [2:0] sel;
		logic [8:0] off;
	} line_word_t;

	// ------------------------------------------------------------------------
	// Scoreboard: line tables, frame buffers, counters and pending results
	// ------------------------------------------------------------------------
	class demux_scoreboard;
		bit [7:0]    open_mask;
		line_state_t buf_state [LINE_COUNT];
		bit [9:0]    buf_fill [LINE_COUNT];
		bit [7:0]    frame_copy [LINE_COUNT][BUF_BYTES];
		rx_mode_t    rx_mode;
		bit [2:0]    cur_line;
		bit [7:0]    line_err_cnt [LINE_COUNT];
		bit [15:0]   line_refused_cnt [LINE_COUNT];
		bit [15:0]   bad_addr_cnt;
		bit [7:0]    abort_cnt;
		bit [7:0]    overrun_cnt;
		result_t     expected_reports [$];
		int          failures;
		int          beats_seen;

		function new();
			open_mask    = '0;
			rx_mode      = RX_IDLE;
			cur_line     = '0;
			bad_addr_cnt = '0;
			abort_cnt    = '0;
			overrun_cnt  = '0;
			failures     = 0;
			beats_seen   = 0;
			foreach (buf_state[i]) begin
				buf_state[i]        = LS_IDLE;
				buf_fill[i]         = '0;
				line_err_cnt[i]     = '0;
				line_refused_cnt[i] = '0;
			end
		endfunction

		task report(string msg);
			failures++;
			if (failures <= PRINT_LIMIT)
				$display("[%0t] MISMATCH %s", $time, msg);
		endtask

		// Closing a line drops it to idle and stops a frame in progress on it
		function void set_open_mask(bit [7:0] m);
			bit [7:0] was;
			was       = open_mask;
			open_mask = m;
			for (int l = 0; l < LINE_COUNT; l++) begin
				if (was[l] && !m[l]) begin
					buf_state[l] = LS_IDLE;
					if (l == cur_line && rx_mode == RX_BUSY)
						rx_mode = RX_DISCARD;
				end
			end
		endfunction

		// Append to the current line; a full buffer drops the rest of the frame
		function void store_byte(bit [7:0] b);
			if (buf_fill[cur_line] >= BUF_BYTES) begin
				rx_mode = RX_DISCARD;
			end else begin
				frame_copy[cur_line][buf_fill[cur_line]] = b;
				buf_fill[cur_line]++;
			end
		endfunction

		function result_t demux_word(line_word_t w);
			result_t  r;
			bit [2:0] rep;
			bit [2:0] addr_line;
			r   = '0;
			rep = cur_line;
			if (w.cmd == CMD_RX) begin
				if (w.som) begin
					// start word: error flags do not matter here
					if (w.rx >= 2 * LINE_COUNT) begin
						bad_addr_cnt++;
						rx_mode         = RX_DISCARD;
						r.frame_ignored = 1'b1;
					end else begin
						addr_line = w.rx[3:1];
						rep       = addr_line;
						if (!open_mask[addr_line] || buf_state[addr_line] == LS_READY) begin
							line_refused_cnt[addr_line]++;
							rx_mode         = RX_DISCARD;
							r.frame_ignored = 1'b1;
						end else begin
							cur_line            = addr_line;
							buf_state[addr_line] = LS_FILL;
							rx_mode             = RX_BUSY;
							buf_fill[addr_line] = '0;
							store_byte(w.rx);
						end
					end
				end else if (w.eom) begin
					// end word: any flag counts an error, else complete if receiving
					if (w.rerr | w.abrt | w.ovr | w.crc) begin
						line_err_cnt[cur_line]++;
					end else if (buf_state[cur_line] == LS_FILL && rx_mode == RX_BUSY) begin
						buf_state[cur_line] = LS_READY;
						r.message_ready     = 1'b1;
						r.ready_line        = cur_line;
					end
					rx_mode = RX_IDLE;
				end else if (w.abrt | w.rerr | w.ovr) begin
					rx_mode = RX_DISCARD;
					if (buf_state[cur_line] == LS_FILL)
						buf_state[cur_line] = LS_IDLE;
					if (w.abrt)
						abort_cnt++;
					if (w.ovr)
						overrun_cnt++;
				end else if (rx_mode == RX_BUSY) begin
					store_byte(w.rx);
				end
			end else begin
				rep = w.sel;
				if (w.cmd == CMD_FETCH) begin
					if (buf_state[w.sel] == LS_READY && w.off < buf_fill[w.sel])
						r.data_byte = frame_copy[w.sel][w.off];
				end else if (w.cmd == CMD_RELEASE && buf_state[w.sel] == LS_READY) begin
					buf_state[w.sel] = LS_IDLE;
				end
			end
			r.line_state     = buf_state[rep];
			r.line_length    = buf_fill[rep];
			r.line_errors    = line_err_cnt[rep];
			r.line_ignored   = line_refused_cnt[rep];
			r.global_ignored = bad_addr_cnt;
			r.abort_count    = abort_cnt;
			r.overrun_count  = overrun_cnt;
			return r;
		endfunction

		function void take_word(line_word_t w);
			expected_reports.push_back(demux_word(w));
		endfunction

		function int pending_count();
			return expected_reports.size();
		endfunction

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("beat %0d %s: got %0d expected %0d",
					beats_seen, name, got, want));
		endtask

		task check_report(result_t got);
			result_t want;
			if (expected_reports.size() == 0) begin
				report($sformatf("beat %0d arrived with nothing expected", beats_seen));
				beats_seen++;
				return;
			end
			want = expected_reports.pop_front();
			compare_field("line_state", got.line_state, want.line_state);
			compare_field("line_length", got.line_length, want.line_length);
			compare_field("data_byte", got.data_byte, want.data_byte);
			compare_field("message_ready", got.message_ready, want.message_ready);
			compare_field("ready_line", got.ready_line, want.ready_line);
			compare_field("frame_ignored", got.frame_ignored, want.frame_ignored);
			compare_field("line_errors", got.line_errors, want.line_errors);
			compare_field("line_ignored", got.line_ignored, want.line_ignored);
			compare_field("global_ignored", got.global_ignored, want.global_ignored);
			compare_field("abort_count", got.abort_count, want.abort_count);
			compare_field("overrun_count", got.overrun_count, want.overrun_count);
			beats_seen++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------------
	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [1:0]            cmd;
	logic [7:0]            rx_byte;
	logic                  start_of_message;
	logic                  end_of_message;
	logic                  receive_error;
	logic                  overrun;
	logic                  crc_error;
	logic                  frame_aborted;
	logic [2:0]            line_select;
	logic [8:0]            byte_offset;
	logic                  empty;
	logic                  pop;
	logic [1:0]            line_state;
	logic [9:0]            line_length;
	logic [7:0]            data_byte;
	logic                  message_ready;
	logic [2:0]            ready_line;
	logic                  frame_ignored;
	logic [7:0]            line_errors;
	logic [15:0]           line_ignored;
	logic [15:0]           global_ignored;
	logic [7:0]            abort_count;
	logic [7:0]            overrun_count;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	sync_frame_line_demultiplexer_core dut (.*);

	demux_scoreboard sb = new();

	int          gap_pct;
	int          stall_pct;
	int          hold_req;
	int          words_sent;
	int unsigned cycle_count = 0;

	always #(CLK_HALF) clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// ------------------------------------------------------------------------
	// Result side: check each popped beat, stall at random or on request
	// ------------------------------------------------------------------------
	initial begin : result_side
		int      stall;
		result_t got;
		stall = 0;
		pop   = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && empty === 1'b0) begin
				got = {line_state, line_length, data_byte, message_ready, ready_line,
					frame_ignored, line_errors, line_ignored, global_ignored,
					abort_count, overrun_count};
				sb.check_report(got);
			end
			@(negedge clk);
			if (hold_req > 0) begin
				stall    = hold_req;
				hold_req = 0;
			end
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				stall = pick_gap() - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Word builders
	// ------------------------------------------------------------------------
	function automatic line_word_t noise_word();
		line_word_t w;
		w.cmd  = 2'($urandom_range(0, 3));
		w.rx   = 8'($urandom);
		w.som  = 1'($urandom);
		w.eom  = 1'($urandom);
		w.rerr = 1'($urandom);
		w.ovr  = 1'($urandom);
		w.crc  = 1'($urandom);
		w.abrt = 1'($urandom);
		w.sel  = 3'($urandom);
		w.off  = 9'($urandom);
		return w;
	endfunction

	function automatic line_word_t start_word(logic [7:0] addr);
		line_word_t w;
		w     = noise_word();
		w.cmd = CMD_RX;
		w.som = 1'b1;
		w.rx  = addr;
		if ($urandom_range(0, 3) != 0)
			{w.eom, w.rerr, w.ovr, w.crc, w.abrt} = '0;
		return w;
	endfunction

	// Plain data; a lone frame check flag still counts as data
	function automatic line_word_t data_word(logic [7:0] b);
		line_word_t w;
		w     = noise_word();
		w.cmd = CMD_RX;
		w.rx  = b;
		{w.som, w.eom, w.rerr, w.ovr, w.abrt} = '0;
		w.crc = ($urandom_range(0, 7) == 0);
		return w;
	endfunction

	function automatic line_word_t end_word(bit clean);
		line_word_t w;
		w     = noise_word();
		w.cmd = CMD_RX;
		w.som = 1'b0;
		w.eom = 1'b1;
		if (clean)
			{w.rerr, w.ovr, w.crc, w.abrt} = '0;
		else
			{w.rerr, w.ovr, w.crc, w.abrt} = 4'($urandom_range(1, 15));
		return w;
	endfunction

	// Abort, receive error or overrun in the middle of a frame
	function automatic line_word_t stop_word();
		line_word_t w;
		w     = noise_word();
		w.cmd = CMD_RX;
		w.som = 1'b0;
		w.eom = 1'b0;
		{w.abrt, w.rerr, w.ovr} = 3'($urandom_range(1, 7));
		return w;
	endfunction

	function automatic line_word_t host_word(logic [1:0] c, logic [2:0] line, logic [8:0] off);
		line_word_t w;
		w     = noise_word();
		w.cmd = c;
		w.sel = line;
		w.off = off;
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// Input side and register port
	// ------------------------------------------------------------------------
	task automatic send_word(line_word_t w);
		int g;
		@(negedge clk);
		cmd              <= w.cmd;
		rx_byte          <= w.rx;
		start_of_message <= w.som;
		end_of_message   <= w.eom;
		receive_error    <= w.rerr;
		overrun          <= w.ovr;
		crc_error        <= w.crc;
		frame_aborted    <= w.abrt;
		line_select      <= w.sel;
		byte_offset      <= w.off;
		push             <= 1'b1;
		do @(posedge clk); while (full !== 1'b0);
		sb.take_word(w);
		words_sent++;
		if ($urandom_range(0, 99) < gap_pct) begin
			g = pick_gap();
			@(negedge clk) push <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// Hold input and wait until every expected beat has been popped
	task automatic wait_drained();
		@(negedge clk) push <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_open_mask(logic [7:0] m);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= OPEN_MASK_ADDR;
		pwdata  <= APB_DATA_W'(m);
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_open_mask(m);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Sometimes leave a frame open so the mask change closes a busy line
	task automatic change_open_mask(logic [7:0] next);
		logic [7:0] m;
		int         l;
		bit         dangling;
		m        = next;
		dangling = (sb.open_mask != 0) && $urandom_range(0, 1);
		if (dangling) begin
			do l = $urandom_range(0, LINE_COUNT - 1); while (!sb.open_mask[l]);
			send_word(start_word(8'({l[2:0], 1'($urandom)})));
			send_word(data_word(8'($urandom)));
			m[l] = 1'b0;
		end
		wait_drained();
		write_open_mask(m);
		if (dangling) begin
			send_word(data_word(8'($urandom)));
			send_word(end_word(1));
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic run_directed();
		line_word_t w;
		// refusals with every line closed, bad addresses, end with nothing open
		send_word(start_word(8'h00));
		send_word(start_word(8'h10));
		send_word(start_word(8'hFF));
		send_word(end_word(1));
		wait_drained();
		write_open_mask(8'hFF);
		// clean frame on line 7; flags on the start word are ignored
		w = start_word(8'h0F);
		{w.eom, w.rerr, w.ovr, w.crc, w.abrt} = '1;
		send_word(w);
		w     = data_word(8'h00);
		w.crc = 1'b1;
		send_word(w);
		send_word(data_word(8'hFF));
		send_word(end_word(1));
		// ready line refuses a new frame; fetch inside and past the frame
		send_word(start_word(8'h0E));
		send_word(host_word(CMD_FETCH, 3'd7, 9'd0));
		send_word(host_word(CMD_FETCH, 3'd7, 9'd2));
		send_word(host_word(CMD_FETCH, 3'd7, 9'd3));
		send_word(host_word(CMD_FETCH, 3'd7, 9'h1FF));
		send_word(host_word(CMD_RELEASE, 3'd7, 9'd0));
		send_word(host_word(CMD_RELEASE, 3'd7, 9'd0));
		// end with every error flag counts one error and nothing else
		send_word(start_word(8'h01));
		send_word(data_word(8'h55));
		w = end_word(1);
		{w.rerr, w.ovr, w.crc, w.abrt} = '1;
		send_word(w);
		// abort with overrun mid-frame, then data and end are dropped
		send_word(start_word(8'h02));
		send_word(data_word(8'h3C));
		w      = stop_word();
		w.abrt = 1'b1;
		w.ovr  = 1'b1;
		w.rerr = 1'b0;
		send_word(w);
		send_word(data_word(8'h99));
		send_word(end_word(1));
		send_word(host_word(CMD_FETCH, 3'd1, 9'd0));
		send_word(host_word(CMD_NOP, 3'd5, 9'd0));
	endtask

	// Fill line 3 to capacity, then one more byte overflows the frame
	task automatic fill_to_overflow();
		gap_pct   = 5;
		stall_pct = 10;
		wait_drained();
		send_word(start_word(8'h06));
		repeat (BUF_BYTES - 1) send_word(data_word(8'($urandom)));
		send_word(data_word(8'hA5));
		send_word(end_word(1));
		send_word(host_word(CMD_FETCH, 3'd3, 9'h1FF));
		send_word(host_word(CMD_FETCH, 3'd3, 9'd0));
	endtask

	task automatic send_frame();
		int         r;
		int         len;
		logic [7:0] addr;
		r    = $urandom_range(0, 99);
		addr = (r < 88) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(16, 255));
		send_word(start_word(addr));
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
		repeat (len) send_word(data_word(8'($urandom)));
		r = $urandom_range(0, 99);
		if (r < 70) begin
			send_word(end_word(1));
		end else if (r < 83) begin
			send_word(end_word(0));
		end else if (r < 93) begin
			send_word(stop_word());
			if ($urandom_range(0, 1))
				send_word(end_word(1));
		end
	endtask

	// Read back bytes of a line, mostly inside what it holds, maybe release it
	task automatic fetch_and_release(logic [2:0] line);
		int       n;
		int       top;
		logic [8:0] off;
		top = (sb.buf_fill[line] > BUF_BYTES - 1) ? BUF_BYTES - 1 : sb.buf_fill[line];
		n   = $urandom_range(1, 6);
		repeat (n) begin
			if ($urandom_range(0, 4) != 0)
				off = 9'($urandom_range(0, top));
			else
				off = 9'($urandom);
			send_word(host_word(CMD_FETCH, line, off));
		end
		if ($urandom_range(0, 1))
			send_word(host_word(CMD_RELEASE, line, 9'($urandom)));
	endtask

	task automatic random_sequence();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			send_frame();
		else if (r < 85)
			fetch_and_release(3'($urandom));
		else if (r < 90)
			send_word(host_word(CMD_RELEASE, 3'($urandom), 9'($urandom)));
		else
			send_word(noise_word());
	endtask

	task automatic run_random_phases();
		logic [7:0] masks [7];
		int         first;
		int         stop_at;
		int         saved_gap;
		masks    = '{8'hFF, 8'h00, 8'h00, 8'h55, 8'hAA, 8'h00, 8'hFF};
		masks[1] = 8'($urandom);
		masks[5] = 8'($urandom);
		first    = words_sent;
		for (int p = 0; p < 7; p++) begin
			change_open_mask(masks[p]);
			case (p % 3)
				0: begin
					gap_pct   = 30;
					stall_pct = 25;
				end
				1: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				default: begin
					gap_pct   = 60;
					stall_pct = 50;
				end
			endcase
			// hold the result side off while words keep coming, so full rises
			if (p == 0) begin
				saved_gap = gap_pct;
				gap_pct   = 0;
				hold_req  = 80;
				stop_at   = words_sent + 30;
				while (words_sent < stop_at)
					send_frame();
				gap_pct = saved_gap;
			end
			stop_at = first + (p + 1) * RANDOM_WORDS / 7;
			while (words_sent < stop_at)
				random_sequence();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		push             = 1'b0;
		cmd              = CMD_RX;
		rx_byte          = '0;
		start_of_message = 1'b0;
		end_of_message   = 1'b0;
		receive_error    = 1'b0;
		overrun          = 1'b0;
		crc_error        = 1'b0;
		frame_aborted    = 1'b0;
		line_select      = '0;
		byte_offset      = '0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		gap_pct          = 30;
		stall_pct        = 25;
		hold_req         = 0;
		words_sent       = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		run_directed();
		fill_to_overflow();
		run_random_phases();

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.pending_count() != 0)
			sb.report($sformatf("%0d expected beats never arrived", sb.pending_count()));
		if (sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
